// File: hdl/sss_pkg.sv
// ----------------------------------------------------------------------------
// sss_pkg : shared definitions for the serial SRAM slave core
// Command codes, fill byte and the structs passed between the submodules.
// ----------------------------------------------------------------------------
package sss_pkg;

	localparam int SSS_MEM_BYTES = 32 * 1024;

	localparam logic [7:0] CMD_WRMODE = 8'h01;
	localparam logic [7:0] CMD_WRITE  = 8'h02;
	localparam logic [7:0] CMD_READ   = 8'h03;
	localparam logic [7:0] CMD_RDMODE = 8'h05;
	localparam logic [7:0] NO_DATA    = 8'hFF;

	// memory access issued by the protocol engine for one beat
	typedef struct packed {
		logic       rd;
		logic       wr;
		logic [7:0] wdata;
	} mem_req_t;

	// reply of one exchange beat: either a ready byte or the memory read data
	typedef struct packed {
		logic       valid;
		logic       from_mem;
		logic [7:0] data;
	} res_t;

endpackage

// File: hdl/sss_mem.sv
// ----------------------------------------------------------------------------
// sss_mem : byte store of the serial SRAM slave
// Single-port synchronous RAM with a registered read and a zeroing
// sweep after reset that covers every entry.
// ----------------------------------------------------------------------------
module sss_mem #(
	parameter int MEM_BYTES = sss_pkg::SSS_MEM_BYTES
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  sss_pkg::mem_req_t            req,
	input  logic [$clog2(MEM_BYTES)-1:0] addr,
	output logic [7:0]                   rdata,
	output logic                         busy
);
	import sss_pkg::*;

	localparam int AW = $clog2(MEM_BYTES);
	localparam logic [AW-1:0] LAST_IDX = AW'(MEM_BYTES - 1);

	logic [7:0]    mem_q [MEM_BYTES];
	logic [7:0]    rdata_q;
	logic          busy_q;
	logic [AW-1:0] clr_idx_q;

	// zeroing sweep: one entry per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b1;
			clr_idx_q <= '0;
		end else if (busy_q) begin
			clr_idx_q <= clr_idx_q + 1'b1;
			if (clr_idx_q == LAST_IDX) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (busy_q) begin
			mem_q[clr_idx_q] <= '0;
		end else if (req.wr) begin
			mem_q[addr] <= req.wdata;
		end
	end

	// read data holds until the next read
	always_ff @(posedge clk) begin
		if (req.rd) begin
			rdata_q <= mem_q[addr];
		end
	end

	assign rdata = rdata_q;
	assign busy  = busy_q;

endmodule

// File: hdl/sss_ctrl.sv
// ----------------------------------------------------------------------------
// sss_ctrl : command and address sequencer of the serial SRAM slave
// Tracks chip select, decodes the command byte, gathers the address and
// issues one memory access per in-range data beat.
// ----------------------------------------------------------------------------
module sss_ctrl #(
	parameter int MEM_BYTES = sss_pkg::SSS_MEM_BYTES
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         accept,
	input  logic                         action,
	input  logic [7:0]                   mosi_byte,
	input  logic                         cs_pin,
	output sss_pkg::mem_req_t            req,
	output logic [$clog2(MEM_BYTES)-1:0] addr,
	output sss_pkg::res_t                res
);
	import sss_pkg::*;

	localparam int AW = $clog2(MEM_BYTES);
	localparam logic [AW:0] MEM_LIM = (AW + 1)'(MEM_BYTES);
	localparam logic [16:0] MEM_LIM17 = 17'(MEM_BYTES);

	localparam logic [2:0] PH_IDLE    = 3'd0;
	localparam logic [2:0] PH_WRMODE  = 3'd1;
	localparam logic [2:0] PH_ADDR_HI = 3'd2;
	localparam logic [2:0] PH_ADDR_LO = 3'd3;
	localparam logic [2:0] PH_READING = 3'd4;
	localparam logic [2:0] PH_WRITING = 3'd5;
	localparam logic [2:0] PH_RDMODE  = 3'd6;

	logic [2:0]    phase_q, phase_d;
	logic          sel_q, sel_d;
	logic          is_read_q, is_read_d;
	logic [7:0]    mode_q, mode_d;
	logic [7:0]    hi_q, hi_d;
	logic [AW-1:0] hm_q, hm_d;
	logic [AW-1:0] red_q, red_d;
	logic          inrange_q, inrange_d;

	logic [AW-1:0] hm_tbl [256];
	logic [AW:0]   lo_sum;
	logic [AW-1:0] lo_red;
	logic [AW:0]   nxt;
	logic [AW-1:0] adv;

	// (high byte * 256) mod size, one entry per high byte
	for (genvar h = 0; h < 256; h++) begin : g_hm
		localparam int unsigned HM = (h * 256) % MEM_BYTES;
		assign hm_tbl[h] = HM[AW-1:0];
	end

	assign lo_sum = {1'b0, hm_q} + (AW + 1)'(mosi_byte);
	assign lo_red = (lo_sum >= MEM_LIM) ? AW'(lo_sum - MEM_LIM) : lo_sum[AW-1:0];
	assign nxt    = {1'b0, red_q} + 1'b1;
	assign adv    = (nxt == MEM_LIM) ? '0 : nxt[AW-1:0];

	always_comb begin
		phase_d   = phase_q;
		sel_d     = sel_q;
		is_read_d = is_read_q;
		mode_d    = mode_q;
		hi_d      = hi_q;
		hm_d      = hm_q;
		red_d     = red_q;
		inrange_d = inrange_q;
		req       = '0;
		req.wdata = mosi_byte;
		res       = '0;
		res.data  = NO_DATA;

		if (accept && action) begin
			// pin update: any change of level drops back to idle
			if (cs_pin == sel_q) begin
				phase_d = PH_IDLE;
			end
			sel_d = !cs_pin;
		end else if (accept) begin
			res.valid = 1'b1;
			if (sel_q) begin
				case (phase_q)
					PH_WRMODE: begin
						mode_d  = mosi_byte;
						phase_d = PH_IDLE;
					end
					PH_RDMODE: begin
						res.data = mode_q;
						phase_d  = PH_IDLE;
					end
					PH_ADDR_HI: begin
						hi_d    = mosi_byte;
						hm_d    = hm_tbl[mosi_byte];
						phase_d = PH_ADDR_LO;
					end
					PH_ADDR_LO: begin
						red_d     = lo_red;
						inrange_d = {1'b0, hi_q, mosi_byte} < MEM_LIM17;
						phase_d   = is_read_q ? PH_READING : PH_WRITING;
					end
					PH_READING: begin
						req.rd       = inrange_q;
						res.from_mem = inrange_q;
						red_d        = adv;
						inrange_d    = 1'b1;
					end
					PH_WRITING: begin
						req.wr    = inrange_q;
						red_d     = adv;
						inrange_d = 1'b1;
					end
					default: begin
						red_d     = '0;
						inrange_d = 1'b1;
						is_read_d = (mosi_byte == CMD_READ);
						if (mosi_byte == CMD_WRMODE) begin
							phase_d = PH_WRMODE;
						end else if (mosi_byte == CMD_RDMODE) begin
							phase_d = PH_RDMODE;
						end else if (mosi_byte == CMD_READ || mosi_byte == CMD_WRITE) begin
							phase_d = PH_ADDR_HI;
						end else begin
							phase_d = PH_IDLE;
						end
					end
				endcase
			end
		end
	end

	assign addr = red_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			sel_q     <= 1'b0;
			is_read_q <= 1'b0;
			mode_q    <= '0;
			red_q     <= '0;
			inrange_q <= 1'b1;
		end else begin
			phase_q   <= phase_d;
			sel_q     <= sel_d;
			is_read_q <= is_read_d;
			mode_q    <= mode_d;
			red_q     <= red_d;
			inrange_q <= inrange_d;
		end
	end

	always_ff @(posedge clk) begin
		hi_q <= hi_d;
		hm_q <= hm_d;
	end

endmodule

// File: hdl/spi_sram_slave_core.sv
// ----------------------------------------------------------------------------
// spi_sram_slave_core : byte-level serial SRAM slave
// Input channel item_* carries SPI exchange beats and chip-select updates;
// output channel res_* returns one miso byte per exchange beat.
//
// Usage:
//   An input beat with action = 0 is a byte exchange and yields exactly one
//   result beat; action = 1 updates the chip-select level and yields none.
//   Each accepted exchange beat passes the reply stage, then the result
//   register. Throughput is one beat per cycle while item_stall is low:
//   the sequencer updates its registers in the accepting cycle and the
//   single-port RAM is read or written at that same edge, its registered
//   read data joining the reply one stage on. After reset the RAM is swept
//   to zero, one byte per cycle, and item_stall stays high until it is done.
//   When the receiver raises res_stall the result register holds, then the
//   reply stage fills and item_stall rises; no beat is ever dropped.
// ----------------------------------------------------------------------------
module spi_sram_slave_core #(
	parameter int MEM_BYTES = sss_pkg::SSS_MEM_BYTES
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       item_valid,
	output logic       item_stall,
	input  logic       action,
	input  logic [7:0] mosi_byte,
	input  logic       cs_pin,
	output logic       res_valid,
	input  logic       res_stall,
	output logic [7:0] miso_byte
);
	import sss_pkg::*;

	localparam int AW = $clog2(MEM_BYTES);

	mem_req_t      req;
	res_t          res;
	logic [AW-1:0] addr;
	logic [7:0]    rdata;
	logic          clr_busy;
	logic          accept;

	// reply stage: byte or pending RAM read
	logic          valid_s1;
	logic          from_mem_s1;
	logic [7:0]    data_s1;

	// result register facing the receiver
	logic          out_valid_q;
	logic [7:0]    miso_q;

	logic          s2_load;
	logic          s1_free;

	assign s2_load    = !out_valid_q || !res_stall;
	assign s1_free    = !valid_s1 || s2_load;
	// hold the input while sweeping or while the reply stage cannot move
	assign item_stall = clr_busy || !s1_free;
	assign accept     = item_valid && !item_stall;

	sss_ctrl #(
		.MEM_BYTES (MEM_BYTES)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.action    (action),
		.mosi_byte (mosi_byte),
		.cs_pin    (cs_pin),
		.req       (req),
		.addr      (addr),
		.res       (res)
	);

	// read and write never hit the same byte in adjacent beats: a command
	// change always lies between them, so no forwarding is needed
	sss_mem #(
		.MEM_BYTES (MEM_BYTES)
	) u_mem (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.addr   (addr),
		.rdata  (rdata),
		.busy   (clr_busy)
	);

	// advance the reply stage whenever it is empty or moving on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s1_free) begin
			valid_s1 <= res.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			from_mem_s1 <= res.from_mem;
			data_s1     <= res.data;
		end
	end

	// RAM data stays put while the stage holds: no read without an accept
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s2_load) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_load && valid_s1) begin
			miso_q <= from_mem_s1 ? rdata : data_s1;
		end
	end

	assign res_valid = out_valid_q;
	assign miso_byte = miso_q;

endmodule

// File: verif/spi_sram_slave_checker.sv
// ----------------------------------------------------------------------------
// spi_sram_slave_checker : protocol predictor and result checker
// Shared beat codes for the bench, and a passive checker that follows the
// serial SRAM protocol on every accepted input beat. It predicts each miso
// byte, holds the predictions in order and compares every accepted result.
// ----------------------------------------------------------------------------
package spi_sram_tb_pkg;

	localparam logic ACT_XFER = 1'b0;	// byte exchange beat
	localparam logic ACT_PIN  = 1'b1;	// chip-select update beat
	localparam logic CS_ON    = 1'b0;	// pin level that selects the slave
	localparam logic CS_OFF   = 1'b1;	// pin level that deselects it

endpackage

module spi_sram_slave_checker #(
	parameter int MEM_BYTES = sss_pkg::SSS_MEM_BYTES
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       item_valid,
	input  logic       item_stall,
	input  logic       action,
	input  logic [7:0] mosi_byte,
	input  logic       cs_pin,
	input  logic       res_valid,
	input  logic       res_stall,
	input  logic [7:0] miso_byte,
	output int         errors,
	output int         pending
);
	import sss_pkg::*;
	import spi_sram_tb_pkg::*;

	typedef enum logic [2:0] {
		SEQ_IDLE       = 3'd0,
		SEQ_MODE_SET   = 3'd1,
		SEQ_ADDR_HI    = 3'd2,
		SEQ_ADDR_LO    = 3'd3,
		SEQ_READ_DATA  = 3'd4,
		SEQ_WRITE_DATA = 3'd5,
		SEQ_MODE_GET   = 3'd6
	} seq_phase_e;

	logic [7:0]  sram_image [MEM_BYTES];
	seq_phase_e  seq;
	logic        rd_cmd;
	logic [15:0] addr;
	logic [7:0]  mode_reg;
	logic        chip_sel;
	logic [7:0]  miso_expected [$];
	logic [7:0]  want;

	task automatic report_mismatch(input string what, input logic [7:0] got,
			input logic [7:0] exp_byte);
		errors++;
		$display("ERROR %0t: %s: got %02h, expected %02h", $time, what, got, exp_byte);
	endtask

	// address wraps at the memory size, out-of-range addresses included
	function automatic logic [15:0] next_address(input logic [15:0] a);
		return 16'((32'(a) + 1) % MEM_BYTES);
	endfunction

	function automatic logic [7:0] miso_for_byte(input logic [7:0] b);
		logic [7:0] reply;
		reply = NO_DATA;
		if (!chip_sel)
			return NO_DATA;
		case (seq)
			SEQ_MODE_SET: begin
				mode_reg = b;
				seq = SEQ_IDLE;
			end
			SEQ_MODE_GET: begin
				reply = mode_reg;
				seq = SEQ_IDLE;
			end
			SEQ_ADDR_HI: begin
				addr = {b, 8'h00};
				seq = SEQ_ADDR_LO;
			end
			SEQ_ADDR_LO: begin
				addr[7:0] = b;
				seq = rd_cmd ? SEQ_READ_DATA : SEQ_WRITE_DATA;
			end
			SEQ_READ_DATA: begin
				if (int'(addr) < MEM_BYTES)
					reply = sram_image[addr];
				addr = next_address(addr);
			end
			SEQ_WRITE_DATA: begin
				if (int'(addr) < MEM_BYTES)
					sram_image[addr] = b;
				addr = next_address(addr);
			end
			default: begin
				addr = 16'h0000;
				rd_cmd = (b == CMD_READ);
				if (b == CMD_WRMODE)
					seq = SEQ_MODE_SET;
				else if (b == CMD_RDMODE)
					seq = SEQ_MODE_GET;
				else if (b == CMD_READ || b == CMD_WRITE)
					seq = SEQ_ADDR_HI;
				else
					seq = SEQ_IDLE;
			end
		endcase
		return reply;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			foreach (sram_image[i])
				sram_image[i] = 8'h00;
			seq = SEQ_IDLE;
			rd_cmd = 1'b0;
			addr = 16'h0000;
			mode_reg = 8'h00;
			chip_sel = 1'b0;
			miso_expected.delete();
			errors = 0;
			pending = 0;
		end else begin
			// retire the result first: it can never belong to this edge's input beat
			if (res_valid && !res_stall) begin
				if (miso_expected.size() == 0) begin
					report_mismatch("result beat with nothing expected", miso_byte, NO_DATA);
				end else begin
					want = miso_expected.pop_front();
					if (miso_byte !== want)
						report_mismatch("miso_byte", miso_byte, want);
				end
			end
			if (item_valid && !item_stall) begin
				if (action == ACT_PIN) begin
					if ((cs_pin == CS_ON) != chip_sel)
						seq = SEQ_IDLE;
					chip_sel = (cs_pin == CS_ON);
				end else begin
					miso_expected.push_back(miso_for_byte(mosi_byte));
				end
			end
			pending = miso_expected.size();
		end
	end

endmodule

// File: verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench : stimulus and verdict for spi_sram_slave_core
// Drives directed and random SPI transactions through the beat interface
// under three idling regimes; the checker beside the core predicts and
// compares every miso byte and reports its failure count here.
// ----------------------------------------------------------------------------
module testbench;
	import sss_pkg::*;
	import spi_sram_tb_pkg::*;

	// the RAM sweep after reset keeps the input stalled while it runs; the limit scales with the memory size
	localparam int QUIET_LIMIT = 4 * SSS_MEM_BYTES;

	logic       clk;
	logic       arst_n;
	logic       item_valid;
	logic       item_stall;
	logic       action;
	logic [7:0] mosi_byte;
	logic       cs_pin;
	logic       res_valid;
	logic       res_stall;
	logic [7:0] miso_byte;

	int errors;
	int pending;
	int src_idle_pct;
	int snk_idle_pct;
	int quiet_cycles;
	int beats_sent;
	int xfers_sent;
	int pins_sent;
	int transactions;

	spi_sram_slave_core dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.action     (action),
		.mosi_byte  (mosi_byte),
		.cs_pin     (cs_pin),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.miso_byte  (miso_byte)
	);

	spi_sram_slave_checker u_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.action     (action),
		.mosi_byte  (mosi_byte),
		.cs_pin     (cs_pin),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.miso_byte  (miso_byte),
		.errors     (errors),
		.pending    (pending)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// receiver: stall at random on the falling edge, at the current rate
	always @(negedge clk) begin
		res_stall <= ($urandom_range(99) < snk_idle_pct);
	end

	// watchdog: count cycles in which neither channel moves a beat
	always @(posedge clk) begin
		if (!arst_n || (item_valid && !item_stall) || (res_valid && !res_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("watchdog: no beat accepted for %0d cycles", QUIET_LIMIT);
			$display("spi_sram_slave_core: mismatch");
			$finish;
		end
	end

	// Present one beat from a falling edge and hold it until accepted.
	// Returns on the falling edge after acceptance, so the next beat can go
	// straight out on that edge without valid dropping in between.
	task automatic send_beat(input logic act, input logic [7:0] b, input logic pin);
		while ($urandom_range(99) < src_idle_pct) begin
			item_valid <= 1'b0;
			@(negedge clk);
		end
		item_valid <= 1'b1;
		action <= act;
		mosi_byte <= b;
		cs_pin <= pin;
		do
			@(posedge clk);
		while (item_stall);
		beats_sent++;
		if (act == ACT_PIN)
			pins_sent++;
		else
			xfers_sent++;
		@(negedge clk);
	endtask

	// chip-select update; the byte field carries noise
	task automatic set_cs(input logic level);
		send_beat(ACT_PIN, 8'($urandom), level);
	endtask

	// byte exchange; the pin field carries noise
	task automatic shift_byte(input logic [7:0] b);
		send_beat(ACT_XFER, b, 1'($urandom));
	endtask

	// Drop valid and hold off until every predicted byte has come back.
	// Always wait for a falling edge before checking, so valid is not raised in the same step.
	task automatic drain();
		item_valid <= 1'b0;
		do
			@(negedge clk);
		while (pending != 0);
	endtask

	// Most bursts land in a small window at the bottom or at the top of the
	// memory so reads meet earlier writes; a few go anywhere or out of range.
	function automatic logic [15:0] pick_address();
		case ($urandom_range(9))
			0: return {8'h7F, 8'hF0 + 8'($urandom_range(15))};
			1: return 16'($urandom);
			2: return {1'b1, 7'($urandom), 8'($urandom)};
			default: return {8'h00, 8'($urandom_range(63))};
		endcase
	endfunction

	task automatic run_transaction();
		int kind;
		int len;
		logic [15:0] start;
		kind = $urandom_range(99);
		len = $urandom_range(1, 8);
		start = pick_address();
		// mostly frame with a fresh select; sometimes carry on from the old state
		if ($urandom_range(9) != 0) begin
			set_cs(CS_OFF);
			set_cs(CS_ON);
		end
		if (kind < 70) begin
			shift_byte(kind < 35 ? CMD_WRITE : CMD_READ);
			shift_byte(start[15:8]);
			shift_byte(start[7:0]);
			repeat (len) begin
				// now and then break the burst with a pin update
				if ($urandom_range(49) == 0)
					set_cs(1'($urandom));
				shift_byte(8'($urandom));
			end
		end else if (kind < 80) begin
			shift_byte(CMD_WRMODE);
			shift_byte(8'($urandom));
		end else if (kind < 88) begin
			shift_byte(CMD_RDMODE);
			shift_byte(8'($urandom));
		end else begin
			// noise: stray pin updates, command-like and arbitrary bytes
			repeat (len) begin
				if ($urandom_range(2) == 0)
					set_cs(1'($urandom));
				else if ($urandom_range(1) == 0)
					shift_byte(8'($urandom_range(7)));
				else
					shift_byte(8'($urandom));
			end
		end
		transactions++;
	endtask

	initial begin
		arst_n = 1'b0;
		item_valid = 1'b0;
		action = ACT_XFER;
		mosi_byte = 8'h00;
		cs_pin = CS_OFF;
		src_idle_pct = 29;
		snk_idle_pct = 51;
		beats_sent = 0;
		xfers_sent = 0;
		pins_sent = 0;
		transactions = 0;
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;

		// exchange while deselected: ignored, answers the fill byte
		shift_byte(8'h00);
		// select, then repeat the same level: no change
		set_cs(CS_ON);
		set_cs(CS_ON);
		// mode reads back as zero after reset, then all ones after a write
		shift_byte(CMD_RDMODE);
		shift_byte(8'hAA);
		shift_byte(CMD_WRMODE);
		shift_byte(8'hFF);
		shift_byte(CMD_RDMODE);
		shift_byte(8'h00);
		// write across the top of the memory: the address wraps to zero
		shift_byte(CMD_WRITE);
		shift_byte(8'h7F);
		shift_byte(8'hFF);
		shift_byte(8'h5A);
		shift_byte(8'hA5);
		set_cs(CS_OFF);
		set_cs(CS_ON);
		// read the same two bytes back through the wrap
		shift_byte(CMD_READ);
		shift_byte(8'h7F);
		shift_byte(8'hFF);
		shift_byte(8'h00);
		shift_byte(8'hFF);
		set_cs(CS_OFF);
		set_cs(CS_ON);
		// write at an out-of-range address: dropped, the address still advances
		shift_byte(CMD_WRITE);
		shift_byte(8'hFF);
		shift_byte(8'hFF);
		shift_byte(8'h11);
		shift_byte(8'h22);
		set_cs(CS_OFF);
		set_cs(CS_ON);
		// unknown command: ignored, phase stays idle
		shift_byte(8'h04);

		// sender idles less than the receiver
		while (beats_sent < 260)
			run_transaction();
		drain();

		// swap the idling rates
		src_idle_pct = 51;
		snk_idle_pct = 29;
		while (beats_sent < 510)
			run_transaction();
		drain();

		// back to back on both sides
		src_idle_pct = 0;
		snk_idle_pct = 0;
		while (beats_sent < 760)
			run_transaction();
		drain();

		// allow for the reply pipeline so a stray result would still be seen
		repeat (8) @(negedge clk);

		$display("summary: %0d beats sent, %0d byte exchanges and %0d chip-select updates",
			beats_sent, xfers_sent, pins_sent);
		$display("summary: %0d random transactions over three idling regimes, %0d failures",
			transactions, errors);
		if (errors == 0)
			$display("spi_sram_slave_core: match");
		else
			$display("spi_sram_slave_core: mismatch");
		$finish;
	end

endmodule
